FILE: sv/ptts_pkg.sv
// Shared constants, codes and controller/datapath interface types for the tick scheduler.
package ptts_pkg;

   localparam int NUM_TASKS = 3;
   localparam int SLOTS     = 4;
   localparam int CH_W      = 2;
   localparam int CNT_W     = 16;
   localparam int CSR_IDX_W = 3;
   localparam int REQ_DW    = 8;
   localparam int RSP_DW    = 8;

   localparam logic [SLOTS-1:0] ACTIVE_MASK =
      SLOTS'((1 << NUM_TASKS) - 1);
   localparam logic [CH_W-1:0] LAST_CH = CH_W'(NUM_TASKS - 1);

   localparam logic [SLOTS-1:0][CNT_W-1:0] SD_INIT = {16'd0, 16'd20, 16'd20, 16'd10};
   localparam logic [SLOTS-1:0][CNT_W-1:0] PD_INIT = {16'd0, 16'd5, 16'd500, 16'd10};

   typedef enum logic [1:0] {
      MODE_TICK     = 2'd0,
      MODE_DISPATCH = 2'd1,
      MODE_ENABLE   = 2'd2,
      MODE_RSVD     = 2'd3
   } ptts_mode_type;

   typedef struct packed {
      logic            do_enable;
      logic            tick_step;
      logic [CH_W-1:0] chan_idx;
      logic            disp_step;
   } ptts_cmd_type;

   typedef struct packed {
      logic pend_any;
      logic pend_one;
      logic slot_free;
   } ptts_stat_type;

endpackage

FILE: sv/ptts_ctrl.sv
// Sequencing state machine: accepts items and steps the datapath through ticks, dispatches and enables.
module ptts_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [1:0]             req_mode,
   input  ptts_pkg::ptts_stat_type stat,
   output ptts_pkg::ptts_cmd_type  cmd
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_TICK = 3'b010,
      ST_DISP = 3'b100
   } ptts_state_type;

   ptts_state_type              state_ff, state_in;
   logic [ptts_pkg::CH_W-1:0]   idx_ff, idx_in;
   logic                        accept;

   assign accept = req_tvalid && (state_ff == ST_IDLE);

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      req_tready    = 1'b0;
      cmd.do_enable = 1'b0;
      cmd.tick_step = 1'b0;
      cmd.chan_idx  = idx_ff;
      cmd.disp_step = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (accept) begin
               case (ptts_pkg::ptts_mode_type'(req_mode))
                  ptts_pkg::MODE_TICK: begin
                     state_in = ST_TICK;
                     idx_in   = '0;
                  end
                  ptts_pkg::MODE_DISPATCH: state_in = ST_DISP;
                  ptts_pkg::MODE_ENABLE:   cmd.do_enable = 1'b1;
                  default: ;
               endcase
            end
         end
         ST_TICK: begin
            cmd.tick_step = 1'b1;
            if (idx_ff == ptts_pkg::LAST_CH) begin
               state_in = ST_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_DISP: begin
            if (!stat.pend_any) begin
               state_in = ST_IDLE;
            end else if (stat.slot_free) begin
               cmd.disp_step = 1'b1;
               if (stat.pend_one) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   // tick pass never addresses a channel beyond the configured count
   a_tick_range: assert property (@(posedge clock) disable iff (reset)
      cmd.tick_step |-> ({1'b0, cmd.chan_idx} < (ptts_pkg::CH_W+1)'(ptts_pkg::NUM_TASKS)))
      else $error("tick step on unused channel");

   // a tick pass ends with the last channel
   a_tick_end: assert property (@(posedge clock) disable iff (reset)
      (cmd.tick_step && cmd.chan_idx == ptts_pkg::LAST_CH) |=> req_tready)
      else $error("tick pass did not return to idle");

endmodule

FILE: sv/ptts_datapath.sv
// Channel state, configuration registers, shared countdown unit and result register.
module ptts_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  ptts_pkg::ptts_cmd_type             cmd,
   output ptts_pkg::ptts_stat_type            stat,
   input  logic [ptts_pkg::CH_W-1:0]          req_channel_id,
   input  logic                              req_enable_value,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [ptts_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ptts_pkg::CNT_W-1:0]         csr_data,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [ptts_pkg::CH_W-1:0]          rsp_channel,
   output logic                              rsp_tlast
);

   logic [ptts_pkg::SLOTS-1:0][ptts_pkg::CNT_W-1:0] sd_ff, sd_in;
   logic [ptts_pkg::SLOTS-1:0][ptts_pkg::CNT_W-1:0] pd_ff, pd_in;
   logic [ptts_pkg::SLOTS-1:0][ptts_pkg::CNT_W-1:0] cd_ff, cd_in;
   logic [ptts_pkg::SLOTS-1:0]                      rdy_ff, rdy_in;
   logic [ptts_pkg::SLOTS-1:0]                      en_ff, en_in;
   logic                                            rsp_valid_ff, rsp_valid_in;
   logic [ptts_pkg::CH_W-1:0]                       rsp_chan_ff, rsp_chan_in;
   logic                                            rsp_last_ff, rsp_last_in;

   logic [ptts_pkg::SLOTS-1:0]                      pend, pend_rest, pend_low;
   logic [ptts_pkg::CH_W-1:0]                       low_id;
   logic [ptts_pkg::CNT_W-1:0]                      cd_cur, cd_dec;
   logic                                            ch_ok;
   logic                                            csr_wr;

   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;

   assign pend      = rdy_ff & ptts_pkg::ACTIVE_MASK;
   assign pend_low  = pend & (~pend + 1'b1);
   assign pend_rest = pend & ~pend_low;

   always_comb begin
      low_id = '0;
      for (int k = ptts_pkg::SLOTS - 1; k >= 0; k--) begin
         if (pend[k]) begin
            low_id = ptts_pkg::CH_W'(k);
         end
      end
   end

   assign stat.pend_any  = |pend;
   assign stat.pend_one  = (|pend) && !(|pend_rest);
   assign stat.slot_free = !rsp_valid_ff || rsp_tready;

   assign cd_cur = cd_ff[cmd.chan_idx];
   assign cd_dec = cd_cur - 1'b1;
   assign ch_ok  = {1'b0, req_channel_id} < (ptts_pkg::CH_W+1)'(ptts_pkg::NUM_TASKS);

   always_comb begin
      sd_in        = sd_ff;
      pd_in        = pd_ff;
      cd_in        = cd_ff;
      rdy_in       = rdy_ff;
      en_in        = en_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_chan_in  = rsp_chan_ff;
      rsp_last_in  = rsp_last_ff;

      if (csr_wr) begin
         if (!csr_index[2]) begin
            sd_in[csr_index[1:0]] = csr_data;
         end else begin
            pd_in[csr_index[1:0]] = csr_data;
         end
      end

      if (cmd.do_enable && ch_ok) begin
         en_in[req_channel_id] = req_enable_value;
         cd_in[req_channel_id] = sd_ff[req_channel_id];
      end

      if (cmd.tick_step && en_ff[cmd.chan_idx] && (cd_cur != '0)) begin
         if (cd_dec == '0) begin
            cd_in[cmd.chan_idx]  = pd_ff[cmd.chan_idx];
            rdy_in[cmd.chan_idx] = 1'b1;
         end else begin
            cd_in[cmd.chan_idx] = cd_dec;
         end
      end

      if (cmd.disp_step) begin
         rdy_in       = rdy_ff & ~pend_low;
         rsp_valid_in = 1'b1;
         rsp_chan_in  = low_id;
         rsp_last_in  = !(|pend_rest);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sd_ff        <= ptts_pkg::SD_INIT;
         pd_ff        <= ptts_pkg::PD_INIT;
         cd_ff        <= ptts_pkg::SD_INIT;
         rdy_ff       <= '0;
         en_ff        <= '1;
         rsp_valid_ff <= 1'b0;
      end else begin
         sd_ff        <= sd_in;
         pd_ff        <= pd_in;
         cd_ff        <= cd_in;
         rdy_ff       <= rdy_in;
         en_ff        <= en_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_chan_ff <= rsp_chan_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid  = rsp_valid_ff;
   assign rsp_channel = rsp_chan_ff;
   assign rsp_tlast   = rsp_last_ff;

   // result register is never overwritten while holding an untaken item
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.disp_step |-> stat.slot_free)
      else $error("dispatch into occupied result register");

   // unused channels never become ready
   a_unused_quiet: assert property (@(posedge clock) disable iff (reset)
      (rdy_ff & ~ptts_pkg::ACTIVE_MASK) == '0)
      else $error("ready flag set on unused channel");

   // a dispatched channel is cleared and shows up in the result register
   a_disp_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.disp_step |=> (rsp_tvalid && !rdy_ff[rsp_channel]))
      else $error("dispatch did not clear flag or present item");

endmodule

FILE: sv/periodic_task_tick_scheduler_top.sv
// Periodic tick scheduler top level: stream ports, controller and datapath.
// Tick item: the shared countdown unit steps one channel per cycle, then the controller idles.
//   Set-enable item: applied as it is accepted. Dispatch: from the dispatch state, one id
//   is registered per cycle while rsp_tready holds; next item taken once the last id is in
//   the result register. An empty dispatch returns to idle without presenting an id.
// Reset is synchronous: configuration returns to defaults, countdowns to their start delays.
module periodic_task_tick_scheduler_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [ptts_pkg::REQ_DW-1:0]          req_tdata,  // [1:0] channel_id, [2] enable_value
   input  logic [1:0]                           req_tuser,  // [1:0] mode
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [ptts_pkg::RSP_DW-1:0]          rsp_tdata,  // [1:0] ready_channel
   output logic                                 rsp_tlast,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [ptts_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [ptts_pkg::CNT_W-1:0]           csr_data
);

   ptts_pkg::ptts_cmd_type   cmd;
   ptts_pkg::ptts_stat_type  stat;
   logic [ptts_pkg::CH_W-1:0] rsp_channel;

   ptts_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_mode   (req_tuser),
      .stat       (stat),
      .cmd        (cmd)
   );

   ptts_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_channel_id   (req_tdata[1:0]),
      .req_enable_value (req_tdata[2]),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_channel      (rsp_channel),
      .rsp_tlast        (rsp_tlast)
   );

   assign rsp_tdata = {{(ptts_pkg::RSP_DW - ptts_pkg::CH_W){1'b0}}, rsp_channel};

endmodule

FILE: test/periodic_task_tick_scheduler_top_tb.sv
// Self-checking testbench for the tick scheduler: directed and random items on the stream ports.
`timescale 1ns / 100ps

module periodic_task_tick_scheduler_top_tb;

   localparam int CYCLE_LIMIT  = 2000;
   localparam int MAX_REPORTS  = 10;
   localparam int DRAIN_CYCLES = 2 * (ptts_pkg::NUM_TASKS + 1) + 4;
   localparam int RANDOM_ITEMS = 120;
   localparam int RANDOM_IDS   = 30;

   typedef enum logic [ptts_pkg::CSR_IDX_W-1:0] {
      REG_START_DELAY_0,
      REG_START_DELAY_1,
      REG_START_DELAY_2,
      REG_START_DELAY_3,
      REG_PERIOD_0,
      REG_PERIOD_1,
      REG_PERIOD_2,
      REG_PERIOD_3
   } csr_reg_type;

   typedef struct {
      logic [ptts_pkg::CH_W-1:0] chan;
      logic                      last;
   } dispatch_id_type;

   logic                            clock      = 1'b0;
   logic                            reset      = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic [ptts_pkg::REQ_DW-1:0]     req_tdata  = '0;
   logic [1:0]                      req_tuser  = ptts_pkg::MODE_TICK;
   logic                            rsp_tready = 1'b0;
   logic                            csr_valid  = 1'b0;
   logic [ptts_pkg::CSR_IDX_W-1:0]  csr_index  = '0;
   logic [ptts_pkg::CNT_W-1:0]      csr_data   = '0;
   logic                            req_tready;
   logic                            rsp_tvalid;
   logic [ptts_pkg::RSP_DW-1:0]     rsp_tdata;
   logic                            rsp_tlast;
   logic                            csr_ready;

   // scheduler state as predicted
   logic [ptts_pkg::CNT_W-1:0]      delay_reg  [ptts_pkg::SLOTS];
   logic [ptts_pkg::CNT_W-1:0]      period_reg [ptts_pkg::SLOTS];
   logic [ptts_pkg::CNT_W-1:0]      count_q    [ptts_pkg::SLOTS];
   bit                              pending_q  [ptts_pkg::SLOTS];
   bit                              enabled_q  [ptts_pkg::SLOTS];

   dispatch_id_type       dispatch_q [$];
   dispatch_id_type       want;
   int                    failures     = 0;
   int                    idle_cycles  = 0;
   int                    ids_expected = 0;
   int                    items_sent   = 0;
   bit                    steady       = 1'b0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   periodic_task_tick_scheduler_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   function automatic void sched_reset();
      delay_reg  = '{16'd10, 16'd20, 16'd20, 16'd0};
      period_reg = '{16'd10, 16'd500, 16'd5, 16'd0};
      for (int k = 0; k < ptts_pkg::SLOTS; k++) begin
         count_q[k]   = delay_reg[k];
         pending_q[k] = 1'b0;
         enabled_q[k] = 1'b1;
      end
   endfunction

   function automatic void sched_csr(csr_reg_type idx, logic [ptts_pkg::CNT_W-1:0] val);
      if (idx < REG_PERIOD_0) begin
         delay_reg[int'(idx)] = val;
      end else begin
         period_reg[int'(idx) - int'(REG_PERIOD_0)] = val;
      end
   endfunction

   function automatic void sched_item(ptts_pkg::ptts_mode_type mode,
                                      logic [ptts_pkg::CH_W-1:0] chan, logic en_val);
      int top;
      case (mode)
         ptts_pkg::MODE_TICK: begin
            for (int k = 0; k < ptts_pkg::NUM_TASKS; k++) begin
               if (enabled_q[k] && count_q[k] != '0) begin
                  count_q[k] = count_q[k] - 1'b1;
                  if (count_q[k] == '0) begin
                     count_q[k]   = period_reg[k];
                     pending_q[k] = 1'b1;
                  end
               end
            end
         end
         ptts_pkg::MODE_DISPATCH: begin
            top = -1;
            for (int k = 0; k < ptts_pkg::NUM_TASKS; k++) begin
               if (pending_q[k]) top = k;
            end
            for (int k = 0; k < ptts_pkg::NUM_TASKS; k++) begin
               if (pending_q[k]) begin
                  dispatch_q.push_back('{chan: ptts_pkg::CH_W'(k), last: (k == top)});
                  pending_q[k] = 1'b0;
                  ids_expected++;
               end
            end
         end
         ptts_pkg::MODE_ENABLE: begin
            if (chan < ptts_pkg::NUM_TASKS) begin
               enabled_q[chan] = en_val;
               count_q[chan]   = delay_reg[chan];
            end
         end
         default: ;
      endcase
   endfunction

   task automatic send_item(ptts_pkg::ptts_mode_type mode, logic [ptts_pkg::CH_W-1:0] chan,
                            logic en_val);
      int gap;
      gap = (!steady && $urandom_range(99) < 11) ? $urandom_range(1, 4) : 0;
      if (gap > 0) begin
         @(negedge clock) req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= ptts_pkg::REQ_DW'({en_val, chan});
      req_tuser  <= mode;
      do @(posedge clock); while (!req_tready);
      sched_item(mode, chan, en_val);
      items_sent++;
   endtask

   task automatic write_csr(csr_reg_type idx, logic [ptts_pkg::CNT_W-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      sched_csr(idx, val);
      @(negedge clock) csr_valid <= 1'b0;
   endtask

   // stop sending, let every id come back, then cover a tick still in flight
   task automatic drain();
      @(negedge clock) req_tvalid <= 1'b0;
      while (dispatch_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic test_empty_dispatch();
      send_item(ptts_pkg::MODE_DISPATCH, 2'd0, 1'b0);
      drain();
   endtask

   // zero period stops ch0 after one firing; zero start delay keeps ch2 silent
   task automatic test_register_extremes();
      write_csr(REG_START_DELAY_0, 16'd1);
      write_csr(REG_START_DELAY_1, 16'hFFFF);
      write_csr(REG_START_DELAY_2, 16'd0);
      write_csr(REG_START_DELAY_3, 16'd1);
      write_csr(REG_PERIOD_0, 16'd0);
      write_csr(REG_PERIOD_1, 16'hFFFF);
      write_csr(REG_PERIOD_2, 16'd1);
      write_csr(REG_PERIOD_3, 16'd1);
      for (int k = 0; k < ptts_pkg::SLOTS; k++)
         send_item(ptts_pkg::MODE_ENABLE, ptts_pkg::CH_W'(k), 1'b1);
      send_item(ptts_pkg::MODE_TICK, 2'd0, 1'b0);
      send_item(ptts_pkg::MODE_TICK, 2'd0, 1'b0);
      send_item(ptts_pkg::MODE_DISPATCH, 2'd0, 1'b0);
      send_item(ptts_pkg::MODE_RSVD, 2'd3, 1'b1);
      send_item(ptts_pkg::MODE_DISPATCH, 2'd0, 1'b0);
      drain();
   endtask

   // disabling a channel keeps its pending flag; unused channel id is ignored
   task automatic test_enable_and_ready();
      write_csr(REG_START_DELAY_1, 16'd1);
      write_csr(REG_START_DELAY_2, 16'd1);
      write_csr(REG_PERIOD_0, 16'd1);
      write_csr(REG_PERIOD_1, 16'd1);
      write_csr(REG_PERIOD_2, 16'd1);
      for (int k = 0; k < ptts_pkg::NUM_TASKS; k++)
         send_item(ptts_pkg::MODE_ENABLE, ptts_pkg::CH_W'(k), 1'b1);
      send_item(ptts_pkg::MODE_TICK, 2'd0, 1'b0);
      send_item(ptts_pkg::MODE_ENABLE, 2'd1, 1'b0);
      send_item(ptts_pkg::MODE_TICK, 2'd0, 1'b0);
      send_item(ptts_pkg::MODE_DISPATCH, 2'd0, 1'b0);
      send_item(ptts_pkg::MODE_TICK, 2'd0, 1'b0);
      send_item(ptts_pkg::MODE_ENABLE, 2'd3, 1'b0);
      send_item(ptts_pkg::MODE_DISPATCH, 2'd0, 1'b0);
      send_item(ptts_pkg::MODE_ENABLE, 2'd1, 1'b1);
      drain();
   endtask

   task automatic test_random_traffic();
      int phase;
      int burst;
      int first_item;
      logic [ptts_pkg::CNT_W-1:0] val;
      phase      = 0;
      first_item = items_sent;
      while ((items_sent - first_item < RANDOM_ITEMS || ids_expected < RANDOM_IDS)
             && phase < 12) begin
         steady = (phase == 1);
         for (int r = 0; r < 2 * ptts_pkg::SLOTS; r++) begin
            case (phase % 4)
               0: begin
                  case ($urandom_range(3))
                     0: val = 16'd0;
                     1: val = 16'd1;
                     2: val = 16'hFFFF;
                     default: val = ptts_pkg::CNT_W'($urandom_range(16'hFFFF));
                  endcase
               end
               1: val = 16'd1;
               default: val = ptts_pkg::CNT_W'($urandom_range(0, 4));
            endcase
            write_csr(csr_reg_type'(r), val);
         end
         for (int k = 0; k < ptts_pkg::NUM_TASKS; k++)
            send_item(ptts_pkg::MODE_ENABLE, ptts_pkg::CH_W'(k), 1'b1);
         repeat (20) begin
            if ($urandom_range(99) < 70) begin
               burst = $urandom_range(1, 6);
               repeat (burst)
                  send_item(ptts_pkg::MODE_TICK, ptts_pkg::CH_W'($urandom_range(3)),
                            1'($urandom));
               send_item(ptts_pkg::MODE_DISPATCH, ptts_pkg::CH_W'($urandom_range(3)),
                         1'($urandom));
            end else begin
               send_item(ptts_pkg::ptts_mode_type'($urandom_range(3)),
                         ptts_pkg::CH_W'($urandom_range(3)), 1'($urandom));
            end
         end
         drain();
         phase++;
      end
      steady = 1'b0;
   endtask

   always @(negedge clock) rsp_tready <= steady || ($urandom_range(99) >= 11);

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (dispatch_q.size() == 0) begin
            failures++;
            if (failures <= MAX_REPORTS)
               $display("unexpected id: tdata=%h tlast=%b", rsp_tdata, rsp_tlast);
         end else begin
            want = dispatch_q.pop_front();
            if (rsp_tdata !== ptts_pkg::RSP_DW'(want.chan) || rsp_tlast !== want.last) begin
               failures++;
               if (failures <= MAX_REPORTS)
                  $display("id mismatch: expected tdata=%h tlast=%b, got tdata=%h tlast=%b",
                           ptts_pkg::RSP_DW'(want.chan), want.last, rsp_tdata, rsp_tlast);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      sched_reset();
      repeat (3) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
      test_empty_dispatch();
      test_register_extremes();
      test_enable_and_ready();
      test_random_traffic();
      drain();
      if (failures == 0 && dispatch_q.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

FILE: filelist.f
sv/ptts_pkg.sv
sv/ptts_ctrl.sv
sv/ptts_datapath.sv
sv/periodic_task_tick_scheduler_top.sv
test/periodic_task_tick_scheduler_top_tb.sv
